### sv/rwl_pkg.sv
// types, constants and codes shared by the reader/writer lock table
// no dependencies; imported by every module of the block
package rwl_pkg;

    localparam int NUM_LOCKS      = 64;
    localparam int NUM_REQUESTERS = 8;
    localparam int MAX_DEPTH      = 255;

    localparam int ACT_W     = 2;
    localparam int REQ_W     = 3;
    localparam int LOCK_AW   = 6;
    localparam int DEPTH_W   = 8;
    localparam int CNT_W     = 4;
    localparam int TOTAL_W   = 14;
    localparam int PAIR_AW   = REQ_W + LOCK_AW;
    localparam int PAIR_DEPTH = NUM_REQUESTERS * NUM_LOCKS;

    typedef enum logic [ACT_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_TRY     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_BUSY        = 3'd1,
        ST_TRY_FAILED  = 3'd2,
        ST_CONFLICT    = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_STILL_HELD  = 3'd5,
        ST_NOT_HELD    = 3'd6,
        ST_LIMIT_QUERY = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SHARED = 2'd1,
        MODE_EXCL   = 2'd2
    } mode_t;

    typedef enum logic {
        OP_INC = 1'b0,
        OP_DEC = 1'b1
    } step_op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECIDE,
        S_DEPTH,
        S_TOTAL,
        S_COUNT,
        S_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [REQ_W-1:0]   requester;
        logic [LOCK_AW-1:0] lock_index;
        logic               want_exclusive;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               held_by_me;
        logic               held_exclusive;
        logic               held_in_asked_mode;
        logic               lock_exclusive;
        logic [CNT_W-1:0]   shared_holders;
        logic [TOTAL_W-1:0] my_total_holds;
    } rsp_t;

    typedef struct packed {
        logic             excl;
        logic [CNT_W-1:0] cnt;
    } lock_entry_t;

    typedef struct packed {
        mode_t              mode;
        logic [DEPTH_W-1:0] depth;
    } pair_entry_t;

    // sequencer to table storage
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [LOCK_AW-1:0] lock_idx;
        logic [PAIR_AW-1:0] pair_idx;
        lock_entry_t        lock_wr;
        pair_entry_t        pair_wr;
    } tbl_cmd_t;

    // table storage to sequencer
    typedef struct packed {
        logic        clear_done;
        lock_entry_t lock_rd;
        pair_entry_t pair_rd;
    } tbl_rsp_t;

    // which counters the shared unit updates for the current request
    typedef struct packed {
        step_op_t op;
        logic     depth_en;
        logic     total_en;
        logic     cnt_en;
    } plan_t;

endpackage

### sv/rwl_incdec.sv
// shared increment/decrement unit used in turn for depth, total and count
// depends on rwl_pkg
module rwl_incdec
    import rwl_pkg::*;
(
    input  logic [TOTAL_W-1:0] a,
    input  step_op_t           op,
    output logic [TOTAL_W-1:0] y
);

    always_comb
    begin
        unique case (op)
            OP_INC: y = a + TOTAL_W'(1);
            OP_DEC: y = a - TOTAL_W'(1);
            default: y = a;
        endcase
    end

endmodule

### sv/rwl_tables.sv
// lock entry and (requester, lock) pair memories with registered reads
// clears both memories after reset, one pair entry per cycle; depends on rwl_pkg
module rwl_tables
    import rwl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_cmd_t cmd,
    output tbl_rsp_t rsp
);

    lock_entry_t lock_mem [NUM_LOCKS];
    pair_entry_t pair_mem [PAIR_DEPTH];

    logic [PAIR_AW-1:0] clr_idx_reg;
    logic [PAIR_AW-1:0] clr_idx_next;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    lock_entry_t        lock_rd_reg;
    pair_entry_t        pair_rd_reg;

    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + PAIR_AW'(1);
            if (clr_idx_reg == PAIR_AW'(PAIR_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_idx_reg  <= clr_idx_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // the lock memory is shallower, so its clear just repeats on the low bits
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            pair_mem[clr_idx_reg]              <= '{mode: MODE_NONE, depth: '0};
            lock_mem[clr_idx_reg[LOCK_AW-1:0]] <= '0;
        end
        else if (cmd.wr)
        begin
            pair_mem[cmd.pair_idx] <= cmd.pair_wr;
            lock_mem[cmd.lock_idx] <= cmd.lock_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            pair_rd_reg <= pair_mem[cmd.pair_idx];
            lock_rd_reg <= lock_mem[cmd.lock_idx];
        end
    end

    assign rsp.clear_done = !clr_busy_reg;
    assign rsp.lock_rd    = lock_rd_reg;
    assign rsp.pair_rd    = pair_rd_reg;

endmodule

### sv/recursive_rw_lock_table_core.sv
// channel | signals                      | payload | direction
// request | req_valid, req_ready         | req_t   | in
// result  | rsp_valid, rsp_ready         | rsp_t   | out
//
// a request passes through accept, table read, decide, then the shared
// inc/dec unit updates depth, hold total and shared count in turn, then write-back
// after reset all 512 pair table entries are cleared; req_ready stays low meanwhile
// a result waits in an output register; a new request is taken while it waits,
// and write-back holds until that register is free
// depends on rwl_pkg, rwl_tables, rwl_incdec
module recursive_rw_lock_table_core
    import rwl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    seq_state_t state_reg, state_next;

    req_t               req_reg, req_next;
    logic               in_range_reg, in_range_next;
    status_t            status_reg, status_next;
    plan_t              plan_reg, plan_next;
    mode_t              mode_reg, mode_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               excl_reg, excl_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [TOTAL_W-1:0] tot_reg [NUM_REQUESTERS];
    logic               tot_we;

    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    tbl_cmd_t tbl_cmd;
    tbl_rsp_t tbl_rsp;

    logic [TOTAL_W-1:0] unit_a;
    logic [TOTAL_W-1:0] unit_y;

    mode_t want_mode;
    logic  out_free;
    rsp_t  result;

    rwl_tables u_tables (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .rsp   (tbl_rsp)
    );

    rwl_incdec u_unit (
        .a  (unit_a),
        .op (plan_reg.op),
        .y  (unit_y)
    );

    always_comb
    begin
        unique case (state_reg)
            S_DEPTH: unit_a = TOTAL_W'(depth_reg);
            S_COUNT: unit_a = TOTAL_W'(cnt_reg);
            default: unit_a = total_reg;
        endcase
    end

    assign want_mode = req_reg.want_exclusive ? MODE_EXCL : MODE_SHARED;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        result.status             = status_reg;
        result.held_by_me         = (mode_reg != MODE_NONE);
        result.held_exclusive     = (mode_reg == MODE_EXCL);
        result.held_in_asked_mode = (mode_reg == want_mode);
        result.lock_exclusive     = excl_reg;
        result.shared_holders     = cnt_reg;
        result.my_total_holds     = total_reg;
        if (!in_range_reg)
        begin
            result                = '0;
            result.status         = ST_NOT_HELD;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        in_range_next  = in_range_reg;
        status_next    = status_reg;
        plan_next      = plan_reg;
        mode_next      = mode_reg;
        depth_next     = depth_reg;
        excl_next      = excl_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        tot_we         = 1'b0;
        req_ready      = 1'b0;

        tbl_cmd.rd       = 1'b0;
        tbl_cmd.wr       = 1'b0;
        tbl_cmd.lock_idx = req_reg.lock_index;
        tbl_cmd.pair_idx = {req_reg.requester, req_reg.lock_index};
        tbl_cmd.lock_wr  = '{excl: excl_reg, cnt: cnt_reg};
        tbl_cmd.pair_wr  = '{mode: mode_reg, depth: depth_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                if (tbl_rsp.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                tbl_cmd.rd    = 1'b1;
                in_range_next = ({1'b0, req_reg.requester} < (REQ_W + 1)'(NUM_REQUESTERS))
                             && ({1'b0, req_reg.lock_index} < (LOCK_AW + 1)'(NUM_LOCKS));
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                mode_next   = tbl_rsp.pair_rd.mode;
                depth_next  = tbl_rsp.pair_rd.depth;
                excl_next   = tbl_rsp.lock_rd.excl;
                cnt_next    = tbl_rsp.lock_rd.cnt;
                total_next  = tot_reg[req_reg.requester];
                status_next = ST_LIMIT_QUERY;
                plan_next   = '{op: OP_INC, depth_en: 1'b0, total_en: 1'b0, cnt_en: 1'b0};
                unique case (action_t'(req_reg.action))
                    ACT_ACQUIRE, ACT_TRY:
                    begin
                        if (tbl_rsp.pair_rd.mode != MODE_NONE)
                        begin
                            if (tbl_rsp.pair_rd.mode != want_mode)
                            begin
                                status_next = ST_CONFLICT;
                            end
                            else if (tbl_rsp.pair_rd.depth >= DEPTH_W'(MAX_DEPTH))
                            begin
                                status_next = ST_LIMIT_QUERY;
                            end
                            else
                            begin
                                status_next        = ST_GRANTED;
                                plan_next.depth_en = 1'b1;
                                plan_next.total_en = 1'b1;
                            end
                        end
                        else if (tbl_rsp.lock_rd.excl
                              || (req_reg.want_exclusive && tbl_rsp.lock_rd.cnt != '0))
                        begin
                            status_next = (action_t'(req_reg.action) == ACT_ACQUIRE)
                                        ? ST_BUSY : ST_TRY_FAILED;
                        end
                        else
                        begin
                            // new hold: depth restarts from zero and steps to one
                            status_next        = ST_GRANTED;
                            mode_next          = want_mode;
                            depth_next         = '0;
                            excl_next          = req_reg.want_exclusive;
                            plan_next.depth_en = 1'b1;
                            plan_next.total_en = 1'b1;
                            plan_next.cnt_en   = !req_reg.want_exclusive;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (tbl_rsp.pair_rd.mode == MODE_NONE || tbl_rsp.pair_rd.depth == '0)
                        begin
                            status_next = ST_NOT_HELD;
                        end
                        else
                        begin
                            plan_next.op       = OP_DEC;
                            plan_next.depth_en = 1'b1;
                            plan_next.total_en = (tot_reg[req_reg.requester] != '0);
                            if (tbl_rsp.pair_rd.depth != DEPTH_W'(1))
                            begin
                                status_next = ST_STILL_HELD;
                            end
                            else
                            begin
                                status_next = ST_RELEASED;
                                mode_next   = MODE_NONE;
                                if (tbl_rsp.pair_rd.mode == MODE_EXCL)
                                begin
                                    excl_next = 1'b0;
                                end
                                else
                                begin
                                    plan_next.cnt_en = (tbl_rsp.lock_rd.cnt != '0);
                                end
                            end
                        end
                    end
                    ACT_QUERY:
                    begin
                        status_next = ST_LIMIT_QUERY;
                    end
                    default:
                    begin
                        status_next = ST_LIMIT_QUERY;
                    end
                endcase
                state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                if (plan_reg.depth_en)
                begin
                    depth_next = unit_y[DEPTH_W-1:0];
                end
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                if (plan_reg.total_en)
                begin
                    total_next = unit_y;
                end
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (plan_reg.cnt_en)
                begin
                    cnt_next = unit_y[CNT_W-1:0];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    tbl_cmd.wr     = in_range_reg;
                    tot_we         = in_range_reg;
                    rsp_next       = result;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REQUESTERS; i++)
            begin
                tot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (tot_we)
            begin
                tot_reg[req_reg.requester] <= total_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        in_range_reg <= in_range_next;
        status_reg   <= status_next;
        plan_reg     <= plan_next;
        mode_reg     <= mode_next;
        depth_reg    <= depth_next;
        excl_reg     <= excl_next;
        cnt_reg      <= cnt_next;
        total_reg    <= total_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> tbl_rsp.clear_done)
        else $error("request taken before table clear finished");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.wr |-> tbl_rsp.clear_done)
        else $error("table write during clear");

    a_depth_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.wr |-> (depth_reg <= DEPTH_W'(MAX_DEPTH)))
        else $error("recursion depth beyond limit written");

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.wr |-> (cnt_reg <= CNT_W'(NUM_REQUESTERS)))
        else $error("shared holder count beyond requester count");

    a_excl_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reg.held_exclusive || rsp_reg.held_by_me))
        else $error("exclusive mode reported without a hold");

endmodule

### tb/tb_recursive_rw_lock_table_core.sv
// self-checking testbench for recursive_rw_lock_table_core: directed lock scenarios,
// the recursion limit and biased random traffic, checked against an in-bench lock table
// depends on rwl_pkg and the core; valid/ready on both channels with random idling
`timescale 1ns / 1ps

module tb_recursive_rw_lock_table_core;
    import rwl_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // in-bench copy of the lock table
    logic               lock_excl    [NUM_LOCKS];
    logic [CNT_W-1:0]   lock_sharers [NUM_LOCKS];
    mode_t              hold_mode    [PAIR_DEPTH];
    logic [DEPTH_W-1:0] hold_depth   [PAIR_DEPTH];
    logic [TOTAL_W-1:0] holds_total  [NUM_REQUESTERS];

    rsp_t pending_lock_results[$];
    rsp_t due;

    recursive_rw_lock_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_lock_table();
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            lock_excl[i] = 1'b0;
            lock_sharers[i] = '0;
        end
        for (int i = 0; i < PAIR_DEPTH; i++)
        begin
            hold_mode[i] = MODE_NONE;
            hold_depth[i] = '0;
        end
        for (int i = 0; i < NUM_REQUESTERS; i++)
            holds_total[i] = '0;
    endfunction

    function automatic rsp_t predict_lock_step(input req_t r);
        int unsigned p;
        int unsigned lk;
        int unsigned who;
        mode_t want;
        mode_t m;
        status_t st;
        rsp_t res;
        who = 32'(r.requester);
        lk = 32'(r.lock_index);
        p = who * NUM_LOCKS + lk;
        want = r.want_exclusive ? MODE_EXCL : MODE_SHARED;
        m = hold_mode[p];
        case (action_t'(r.action))
            ACT_ACQUIRE, ACT_TRY:
            begin
                if (m != MODE_NONE)
                begin
                    if (m != want)
                        st = ST_CONFLICT;
                    else if (hold_depth[p] >= MAX_DEPTH)
                        st = ST_LIMIT_QUERY;
                    else
                    begin
                        hold_depth[p] = hold_depth[p] + 1'b1;
                        holds_total[who] = holds_total[who] + 1'b1;
                        st = ST_GRANTED;
                    end
                end
                else if (lock_excl[lk] || (want == MODE_EXCL && lock_sharers[lk] != 0))
                    st = (action_t'(r.action) == ACT_ACQUIRE) ? ST_BUSY : ST_TRY_FAILED;
                else
                begin
                    if (want == MODE_EXCL)
                        lock_excl[lk] = 1'b1;
                    else
                        lock_sharers[lk] = lock_sharers[lk] + 1'b1;
                    hold_mode[p] = want;
                    hold_depth[p] = DEPTH_W'(1);
                    holds_total[who] = holds_total[who] + 1'b1;
                    st = ST_GRANTED;
                end
            end
            ACT_RELEASE:
            begin
                if (m == MODE_NONE || hold_depth[p] == 0)
                    st = ST_NOT_HELD;
                else
                begin
                    hold_depth[p] = hold_depth[p] - 1'b1;
                    if (holds_total[who] != 0)
                        holds_total[who] = holds_total[who] - 1'b1;
                    if (hold_depth[p] != 0)
                        st = ST_STILL_HELD;
                    else
                    begin
                        if (m == MODE_EXCL)
                            lock_excl[lk] = 1'b0;
                        else if (lock_sharers[lk] != 0)
                            lock_sharers[lk] = lock_sharers[lk] - 1'b1;
                        hold_mode[p] = MODE_NONE;
                        st = ST_RELEASED;
                    end
                end
            end
            default: st = ST_LIMIT_QUERY;
        endcase
        m = hold_mode[p];
        res.status = st;
        res.held_by_me = (m != MODE_NONE);
        res.held_exclusive = (m == MODE_EXCL);
        res.held_in_asked_mode = (m == want);
        res.lock_exclusive = lock_excl[lk];
        res.shared_holders = lock_sharers[lk];
        res.my_total_holds = holds_total[who];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // sender: optional gap, then hold the request until it is taken
    task automatic send_request(input action_t act, input int unsigned who,
                                input int unsigned lk, input bit excl);
        req_t item;
        item.action = act;
        item.requester = who[REQ_W-1:0];
        item.lock_index = lk[LOCK_AW-1:0];
        item.want_exclusive = excl;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
        pending_lock_results = {pending_lock_results, predict_lock_step(item)};
    endtask

    task automatic wait_results_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_lock_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_exclusive_paths();
        idle_pct = 0;
        stall_pct = 0;
        send_request(ACT_ACQUIRE, 0, 0, 1'b1);
        send_request(ACT_TRY, 0, 0, 1'b1);
        send_request(ACT_QUERY, 0, 0, 1'b0);
        // holder asking the other mode
        send_request(ACT_ACQUIRE, 0, 0, 1'b0);
        send_request(ACT_TRY, 0, 0, 1'b0);
        // other requester blocked in both modes
        send_request(ACT_ACQUIRE, 1, 0, 1'b1);
        send_request(ACT_TRY, 1, 0, 1'b1);
        send_request(ACT_ACQUIRE, 1, 0, 1'b0);
        send_request(ACT_TRY, 1, 0, 1'b0);
        send_request(ACT_RELEASE, 0, 0, 1'b0);
        send_request(ACT_RELEASE, 0, 0, 1'b1);
        send_request(ACT_RELEASE, 0, 0, 1'b1);
        send_request(ACT_ACQUIRE, 7, 63, 1'b1);
        send_request(ACT_RELEASE, 7, 63, 1'b0);
    endtask

    task automatic test_shared_paths();
        idle_pct = 0;
        stall_pct = 61;
        for (int who = 0; who < NUM_REQUESTERS - 1; who++)
            send_request((who % 2) ? ACT_TRY : ACT_ACQUIRE, who, 63, 1'b0);
        send_request(ACT_ACQUIRE, 7, 63, 1'b1);
        send_request(ACT_TRY, 7, 63, 1'b1);
        send_request(ACT_ACQUIRE, 7, 63, 1'b0);
        send_request(ACT_TRY, 3, 63, 1'b1);
        send_request(ACT_QUERY, 5, 63, 1'b1);
        for (int who = 0; who < NUM_REQUESTERS; who++)
            send_request(ACT_RELEASE, who, 63, who[0]);
        // hold off until the table has answered everything
        wait_results_drained();
    endtask

    // lock stays held one level below the limit afterwards
    task automatic test_recursion_limit();
        idle_pct = 8;
        stall_pct = 8;
        for (int i = 0; i < MAX_DEPTH; i++)
            send_request(i[0] ? ACT_TRY : ACT_ACQUIRE, 5, 42, 1'b1);
        send_request(ACT_ACQUIRE, 5, 42, 1'b1);
        send_request(ACT_TRY, 5, 42, 1'b1);
        send_request(ACT_QUERY, 5, 42, 1'b1);
        send_request(ACT_RELEASE, 5, 42, 1'b1);
    endtask

    // random traffic focused on a few locks so requesters contend
    task automatic run_lock_traffic(input int count);
        int unsigned who;
        int unsigned lk;
        int unsigned pick;
        int unsigned p;
        bit excl;
        action_t act;
        for (int i = 0; i < count; i++)
        begin
            who = $urandom_range(0, NUM_REQUESTERS - 1);
            lk = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                               : $urandom_range(0, NUM_LOCKS - 1);
            p = who * NUM_LOCKS + lk;
            pick = $urandom_range(0, 99);
            if (hold_mode[p] != MODE_NONE)
            begin
                act = (pick < 35) ? ACT_RELEASE : (pick < 60) ? ACT_ACQUIRE :
                      (pick < 85) ? ACT_TRY : ACT_QUERY;
                excl = ($urandom_range(0, 99) < 75) ? (hold_mode[p] == MODE_EXCL)
                                                    : ($urandom_range(0, 1) != 0);
            end
            else
            begin
                act = (pick < 40) ? ACT_ACQUIRE : (pick < 75) ? ACT_TRY :
                      (pick < 90) ? ACT_RELEASE : ACT_QUERY;
                excl = ($urandom_range(0, 99) < 35);
            end
            send_request(act, who, lk, excl);
        end
    endtask

    task automatic test_random_traffic();
        idle_pct = 0;
        stall_pct = 0;
        run_lock_traffic(75);
        idle_pct = 61;
        stall_pct = 0;
        run_lock_traffic(75);
        wait_results_drained();
        idle_pct = 0;
        stall_pct = 61;
        run_lock_traffic(75);
        idle_pct = 8;
        stall_pct = 8;
        run_lock_traffic(75);
    endtask

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_lock_results.size() == 0)
                report_mismatch("result arrived with no request outstanding");
            else
            begin
                due = pending_lock_results.pop_front();
                if (rsp.status != due.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, due.status));
                if (rsp.held_by_me != due.held_by_me)
                    report_mismatch($sformatf("held_by_me %0b, expected %0b",
                                              rsp.held_by_me, due.held_by_me));
                if (rsp.held_exclusive != due.held_exclusive)
                    report_mismatch($sformatf("held_exclusive %0b, expected %0b",
                                              rsp.held_exclusive, due.held_exclusive));
                if (rsp.held_in_asked_mode != due.held_in_asked_mode)
                    report_mismatch($sformatf("held_in_asked_mode %0b, expected %0b",
                                              rsp.held_in_asked_mode,
                                              due.held_in_asked_mode));
                if (rsp.lock_exclusive != due.lock_exclusive)
                    report_mismatch($sformatf("lock_exclusive %0b, expected %0b",
                                              rsp.lock_exclusive, due.lock_exclusive));
                if (rsp.shared_holders != due.shared_holders)
                    report_mismatch($sformatf("shared_holders %0d, expected %0d",
                                              rsp.shared_holders, due.shared_holders));
                if (rsp.my_total_holds != due.my_total_holds)
                    report_mismatch($sformatf("my_total_holds %0d, expected %0d",
                                              rsp.my_total_holds, due.my_total_holds));
            end
        end
    end

    // watchdog on cycles with no request or result taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** recursive_rw_lock_table_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        clear_lock_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_exclusive_paths();
        test_shared_paths();
        test_recursion_limit();
        test_random_traffic();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** recursive_rw_lock_table_core: PASSED **");
        else
            $display("** recursive_rw_lock_table_core: FAILED **");
        $finish;
    end

endmodule
